@@ design/ppio_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_pkg
// Shared types and codes of the mode-0 parallel port: operation and address
// codes, control word constants and the item structures.
// ----------------------------------------------------------------------------
package ppio_pkg;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_IRQ_SET = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ADDR_PORT_A = 2'd0,
		ADDR_PORT_B = 2'd1,
		ADDR_PORT_C = 2'd2,
		ADDR_CTRL   = 2'd3
	} addr_t;

	typedef enum logic [1:0] {
		PAUSE_NONE   = 2'd0,
		PAUSE_RESUME = 2'd1,
		PAUSE_PAUSE  = 2'd2
	} pause_cmd_t;

	// Bit set/reset selector codes (control word bits 3..1).
	localparam logic [2:0] BSR_AUDIO = 3'd0;
	localparam logic [2:0] BSR_TAPE  = 3'd1;
	localparam logic [2:0] BSR_IRQ   = 3'd2;
	localparam logic [2:0] BSR_MOTOR = 3'd3;

	localparam logic [7:0] MODE_CLEAR  = 8'h8A;
	localparam logic [3:0] COLUMN_LAST = 4'd9;
	localparam logic [3:0] COLUMN_NONE = 4'd10;
	localparam logic [7:0] READ_NONE   = 8'hFF;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] addr;
		logic [7:0] wdata;
		logic [7:0] port_b_pins;
		logic       vblank_in;
		logic       cursor_timer_in;
		logic       tape_data_in;
		logic       tape_stopped;
		logic       tape_paused;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] key_column;
		logic       joy1_enable;
		logic       joy2_enable;
		logic       audio_gate;
		logic       tape_data_out;
		logic       tape_data_changed;
		logic       irq_mask;
		logic       cursor_reset_pulse;
		logic       audio_recheck_pulse;
		logic       irq_recheck_pulse;
		logic [1:0] pause_cmd;
	} out_item_t;

endpackage

@@ design/ppio_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_if
// Valid/ready channels of the parallel port: bus access items in, results out.
// ----------------------------------------------------------------------------
interface ppio_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] addr;
	logic [7:0] wdata;
	logic [7:0] port_b_pins;
	logic       vblank_in;
	logic       cursor_timer_in;
	logic       tape_data_in;
	logic       tape_stopped;
	logic       tape_paused;

	modport source (
		output valid, op, addr, wdata, port_b_pins, vblank_in, cursor_timer_in,
		       tape_data_in, tape_stopped, tape_paused,
		input  ready
	);
	modport sink (
		input  valid, op, addr, wdata, port_b_pins, vblank_in, cursor_timer_in,
		       tape_data_in, tape_stopped, tape_paused,
		output ready
	);
endinterface

interface ppio_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] key_column;
	logic       joy1_enable;
	logic       joy2_enable;
	logic       audio_gate;
	logic       tape_data_out;
	logic       tape_data_changed;
	logic       irq_mask;
	logic       cursor_reset_pulse;
	logic       audio_recheck_pulse;
	logic       irq_recheck_pulse;
	logic [1:0] pause_cmd;

	modport source (
		output valid, read_data, key_column, joy1_enable, joy2_enable, audio_gate,
		       tape_data_out, tape_data_changed, irq_mask, cursor_reset_pulse,
		       audio_recheck_pulse, irq_recheck_pulse, pause_cmd,
		input  ready
	);
	modport sink (
		input  valid, read_data, key_column, joy1_enable, joy2_enable, audio_gate,
		       tape_data_out, tape_data_changed, irq_mask, cursor_reset_pulse,
		       audio_recheck_pulse, irq_recheck_pulse, pause_cmd,
		output ready
	);
endinterface

@@ design/ppio_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_in_stage
// Input register: captures one bus access item and holds it until the core
// processes it.
// ----------------------------------------------------------------------------
module ppio_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	ppio_in_if.sink            in_ch,
	input  logic               advance,
	output logic               valid_s1,
	output ppio_pkg::in_item_t item_s1
);
	import ppio_pkg::*;

	logic take;

	assign in_ch.ready = !valid_s1 || advance;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op              <= in_ch.op;
			item_s1.addr            <= in_ch.addr;
			item_s1.wdata           <= in_ch.wdata;
			item_s1.port_b_pins     <= in_ch.port_b_pins;
			item_s1.vblank_in       <= in_ch.vblank_in;
			item_s1.cursor_timer_in <= in_ch.cursor_timer_in;
			item_s1.tape_data_in    <= in_ch.tape_data_in;
			item_s1.tape_stopped    <= in_ch.tape_stopped;
			item_s1.tape_paused     <= in_ch.tape_paused;
		end
	end

endmodule

@@ design/ppio_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_core
// Port registers and the decode of one bus access: reads, port writes, bit
// set/reset, mode word, direct IRQ mask set and the cassette motor edge logic.
// ----------------------------------------------------------------------------
module ppio_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shortcut_mode,
	input  logic                advance,
	input  ppio_pkg::in_item_t  item_s1,
	output ppio_pkg::out_item_t result
);
	import ppio_pkg::*;

	typedef struct packed {
		logic [7:0] port_a;
		logic [3:0] column;
		logic       joy1;
		logic       joy2;
		logic       audio;
		logic       tape;
		logic       irq;
		logic       motor;
		logic       sense;
	} port_state_t;

	port_state_t state_q;
	port_state_t nxt;
	logic [7:0]  rd;
	logic        cursor_pulse;
	logic        flag_audio;
	logic        flag_irq;
	logic        flag_tape;
	logic        tape_wr;
	logic        tape_bit;
	logic        motor_wr;
	logic        motor_bit;
	logic        sense_rd;
	logic [3:0]  nib;
	pause_cmd_t  pause;

	assign nib      = item_s1.wdata[3:0];
	assign sense_rd = shortcut_mode ? state_q.sense
	                                : !(item_s1.tape_stopped || item_s1.tape_paused);

	always_comb begin
		nxt          = state_q;
		rd           = 8'd0;
		cursor_pulse = 1'b0;
		flag_audio   = 1'b0;
		flag_irq     = 1'b0;
		flag_tape    = 1'b0;
		tape_wr      = 1'b0;
		tape_bit     = 1'b0;
		motor_wr     = 1'b0;
		motor_bit    = 1'b0;
		pause        = PAUSE_NONE;

		unique case (op_t'(item_s1.op))
			OP_READ: begin
				unique case (addr_t'(item_s1.addr))
					ADDR_PORT_A: rd = (state_q.column <= COLUMN_LAST) ? state_q.port_a
					                                                  : READ_NONE;
					ADDR_PORT_B: rd = item_s1.port_b_pins;
					ADDR_PORT_C: rd = {item_s1.vblank_in, item_s1.cursor_timer_in,
					                   item_s1.tape_data_in, sense_rd, 1'b0,
					                   state_q.irq, 1'b0, state_q.audio};
					ADDR_CTRL:   rd = 8'd0;
				endcase
			end
			OP_WRITE: begin
				unique case (addr_t'(item_s1.addr))
					ADDR_PORT_A: begin
						nxt.port_a   = item_s1.wdata;
						nxt.column   = (nib <= COLUMN_LAST) ? nib : COLUMN_NONE;
						nxt.joy1     = !item_s1.wdata[5];
						nxt.joy2     = !item_s1.wdata[6];
						cursor_pulse = !item_s1.wdata[7];
					end
					ADDR_PORT_B: begin
					end
					ADDR_PORT_C: begin
						nxt.audio  = item_s1.wdata[0];
						flag_audio = 1'b1;
						tape_wr    = 1'b1;
						tape_bit   = item_s1.wdata[1];
						nxt.irq    = item_s1.wdata[2];
						flag_irq   = 1'b1;
						motor_wr   = 1'b1;
						motor_bit  = item_s1.wdata[3];
					end
					ADDR_CTRL: begin
						if (item_s1.wdata[7]) begin
							// Only the one supported mode word does anything.
							if (item_s1.wdata == MODE_CLEAR) begin
								nxt.port_a = 8'd0;
								nxt.column = 4'd0;
								nxt.audio  = 1'b0;
								nxt.irq    = 1'b0;
								tape_wr    = 1'b1;
								flag_audio = 1'b1;
								flag_irq   = 1'b1;
							end
						end else begin
							unique case (item_s1.wdata[3:1])
								BSR_AUDIO: begin
									nxt.audio  = item_s1.wdata[0];
									flag_audio = 1'b1;
								end
								BSR_TAPE: begin
									tape_wr  = 1'b1;
									tape_bit = item_s1.wdata[0];
								end
								BSR_IRQ: begin
									nxt.irq  = item_s1.wdata[0];
									flag_irq = 1'b1;
								end
								BSR_MOTOR: begin
									motor_wr  = 1'b1;
									motor_bit = item_s1.wdata[0];
								end
								default: begin
								end
							endcase
						end
					end
				endcase
			end
			OP_IRQ_SET: nxt.irq = item_s1.wdata[0];
			OP_NOP: begin
			end
		endcase

		if (tape_wr && (tape_bit != state_q.tape)) begin
			nxt.tape  = tape_bit;
			flag_tape = 1'b1;
		end

		if (motor_wr) begin
			nxt.motor = motor_bit;
			// A rising edge on motor control either flips the local sense or, unless
			// the tape is stopped, asks the transport to pause or resume.
			if (!state_q.motor && motor_bit) begin
				if (shortcut_mode) begin
					nxt.sense = !state_q.sense;
				end else if (!item_s1.tape_stopped) begin
					pause = item_s1.tape_paused ? PAUSE_RESUME : PAUSE_PAUSE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	always_comb begin
		result.read_data           = rd;
		result.key_column          = nxt.column;
		result.joy1_enable         = nxt.joy1;
		result.joy2_enable         = nxt.joy2;
		result.audio_gate          = nxt.audio;
		result.tape_data_out       = nxt.tape;
		result.tape_data_changed   = flag_tape;
		result.irq_mask            = nxt.irq;
		result.cursor_reset_pulse  = cursor_pulse;
		result.audio_recheck_pulse = flag_audio;
		result.irq_recheck_pulse   = flag_irq;
		result.pause_cmd           = pause;
	end

endmodule

@@ design/ppio_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module ppio_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ppio_pkg::out_item_t result,
	output logic                free,
	ppio_out_if.source          out_ch
);
	import ppio_pkg::*;

	logic      valid_s2;
	out_item_t item_s2;

	assign free = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= result;
		end
	end

	assign out_ch.valid               = valid_s2;
	assign out_ch.read_data           = item_s2.read_data;
	assign out_ch.key_column          = item_s2.key_column;
	assign out_ch.joy1_enable         = item_s2.joy1_enable;
	assign out_ch.joy2_enable         = item_s2.joy2_enable;
	assign out_ch.audio_gate          = item_s2.audio_gate;
	assign out_ch.tape_data_out       = item_s2.tape_data_out;
	assign out_ch.tape_data_changed   = item_s2.tape_data_changed;
	assign out_ch.irq_mask            = item_s2.irq_mask;
	assign out_ch.cursor_reset_pulse  = item_s2.cursor_reset_pulse;
	assign out_ch.audio_recheck_pulse = item_s2.audio_recheck_pulse;
	assign out_ch.irq_recheck_pulse   = item_s2.irq_recheck_pulse;
	assign out_ch.pause_cmd           = item_s2.pause_cmd;

endmodule

@@ design/parallel_port_keyboard_tape_io.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_keyboard_tape_io
// Mode-0 parallel port for keyboard, joystick strobes, audio gate and cassette.
// ----------------------------------------------------------------------------
// The port takes one bus access item per clock and returns one result item
// for each, in order. An accepted item is held in the input register, then a
// single decode pass updates the port registers and loads the result register,
// from which the result is offered. Throughput is one item per cycle for as
// long as the consumer keeps ready high; when the result register is held, the
// input register takes one more item only if it is empty, then ready drops.
// The shortcut mode register is written through cfg_we/cfg_wdata and should
// only change while no item is in flight.
module parallel_port_keyboard_tape_io (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	ppio_in_if.sink    in_ch,
	ppio_out_if.source out_ch
);
	import ppio_pkg::*;

	logic      shortcut_q;
	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result;
	logic      out_free;
	logic      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shortcut_q <= 1'b0;
		end else if (cfg_we) begin
			shortcut_q <= cfg_wdata;
		end
	end

	assign advance = valid_s1 && out_free;

	ppio_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ppio_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.shortcut_mode (shortcut_q),
		.advance       (advance),
		.item_s1       (item_s1),
		.result        (result)
	);

	ppio_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule

@@ design/ppio_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_checker
// Port-level checks of the parallel port, bound to the top level.
// ----------------------------------------------------------------------------
module ppio_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic [3:0] key_column,
	input logic       tape_data_changed,
	input logic       cursor_reset_pulse,
	input logic       audio_recheck_pulse,
	input logic       irq_recheck_pulse,
	input logic [1:0] pause_cmd
);
	import ppio_pkg::*;

	// A result that was offered and not taken is still offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item withdrawn before it was taken");

	// Input backpressure only comes from a stalled result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the output side was free");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_column <= COLUMN_NONE)
		else $error("keyboard column out of range");

	// Nonzero read data comes only from a read, which raises no side effects.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> !tape_data_changed && !cursor_reset_pulse
			&& !audio_recheck_pulse && !irq_recheck_pulse && pause_cmd == PAUSE_NONE)
		else $error("read result carries a write side effect");

endmodule

bind parallel_port_keyboard_tape_io ppio_checker u_ppio_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_ready            (in_ch.ready),
	.out_valid           (out_ch.valid),
	.out_ready           (out_ch.ready),
	.read_data           (out_ch.read_data),
	.key_column          (out_ch.key_column),
	.tape_data_changed   (out_ch.tape_data_changed),
	.cursor_reset_pulse  (out_ch.cursor_reset_pulse),
	.audio_recheck_pulse (out_ch.audio_recheck_pulse),
	.irq_recheck_pulse   (out_ch.irq_recheck_pulse),
	.pause_cmd           (out_ch.pause_cmd)
);

@@ sim/ppio_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppio_scoreboard
// Watches both channels of the parallel port, predicts the result of every
// accepted bus access from its own copy of the port registers and compares
// each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ppio_scoreboard (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	ppio_in_if         mon_in,
	ppio_out_if        mon_out,
	output int         fails,
	output int         pending
);
	import ppio_pkg::*;

	logic [7:0] latch_a;
	logic [3:0] column;
	logic       joy1;
	logic       joy2;
	logic       gate;
	logic       tape_bit;
	logic       irq_en;
	logic       motor_bit;
	logic       motor_sense;
	logic       shortcut;

	out_item_t  response_q[$];
	int         reported;

	// Motor control write; a rising edge either flips the sense bit or, unless
	// the tape is stopped, asks the transport to pause or resume.
	function automatic void motor_write(logic b, in_item_t it, inout out_item_t r);
		logic prev;
		prev = motor_bit;
		motor_bit = b;
		if (!prev && b) begin
			if (shortcut)
				motor_sense = ~motor_sense;
			else if (!it.tape_stopped)
				r.pause_cmd = it.tape_paused ? PAUSE_RESUME : PAUSE_PAUSE;
		end
	endfunction

	function automatic void tape_write(logic b, inout out_item_t r);
		if (b != tape_bit) begin
			tape_bit = b;
			r.tape_data_changed = 1'b1;
		end
	endfunction

	function automatic out_item_t port_response(in_item_t it);
		out_item_t r;
		logic      sense;
		r = '0;
		r.pause_cmd = PAUSE_NONE;
		case (op_t'(it.op))
			OP_READ: begin
				case (addr_t'(it.addr))
					ADDR_PORT_A: r.read_data = (column <= COLUMN_LAST) ? latch_a : READ_NONE;
					ADDR_PORT_B: r.read_data = it.port_b_pins;
					ADDR_PORT_C: begin
						sense = shortcut ? motor_sense : !(it.tape_stopped || it.tape_paused);
						r.read_data = {it.vblank_in, it.cursor_timer_in, it.tape_data_in,
							sense, 1'b0, irq_en, 1'b0, gate};
					end
					default: r.read_data = 8'h00;
				endcase
			end
			OP_WRITE: begin
				case (addr_t'(it.addr))
					ADDR_PORT_A: begin
						latch_a = it.wdata;
						column = (it.wdata[3:0] <= COLUMN_LAST) ? it.wdata[3:0] : COLUMN_NONE;
						joy1 = !it.wdata[5];
						joy2 = !it.wdata[6];
						r.cursor_reset_pulse = !it.wdata[7];
					end
					ADDR_PORT_C: begin
						gate = it.wdata[0];
						r.audio_recheck_pulse = 1'b1;
						tape_write(it.wdata[1], r);
						irq_en = it.wdata[2];
						r.irq_recheck_pulse = 1'b1;
						motor_write(it.wdata[3], it, r);
					end
					ADDR_CTRL: begin
						if (it.wdata[7]) begin
							if (it.wdata == MODE_CLEAR) begin
								latch_a = 8'h00;
								column = 4'd0;
								gate = 1'b0;
								tape_write(1'b0, r);
								irq_en = 1'b0;
								r.audio_recheck_pulse = 1'b1;
								r.irq_recheck_pulse = 1'b1;
							end
						end else begin
							case (it.wdata[3:1])
								BSR_AUDIO: begin
									gate = it.wdata[0];
									r.audio_recheck_pulse = 1'b1;
								end
								BSR_TAPE: tape_write(it.wdata[0], r);
								BSR_IRQ: begin
									irq_en = it.wdata[0];
									r.irq_recheck_pulse = 1'b1;
								end
								BSR_MOTOR: motor_write(it.wdata[0], it, r);
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end
			OP_IRQ_SET: irq_en = it.wdata[0];
			default: ;
		endcase
		r.key_column = column;
		r.joy1_enable = joy1;
		r.joy2_enable = joy2;
		r.audio_gate = gate;
		r.tape_data_out = tape_bit;
		r.irq_mask = irq_en;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		in_item_t  acc;
		out_item_t got;
		out_item_t want;
		string     bad;
		if (!arst_n) begin
			latch_a = 8'h00;
			column = 4'd0;
			joy1 = 1'b0;
			joy2 = 1'b0;
			gate = 1'b0;
			tape_bit = 1'b0;
			irq_en = 1'b0;
			motor_bit = 1'b0;
			motor_sense = 1'b0;
			shortcut = 1'b0;
			response_q.delete();
			reported = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (mon_in.valid && mon_in.ready) begin
				acc = {mon_in.op, mon_in.addr, mon_in.wdata, mon_in.port_b_pins,
					mon_in.vblank_in, mon_in.cursor_timer_in, mon_in.tape_data_in,
					mon_in.tape_stopped, mon_in.tape_paused};
				response_q.push_back(port_response(acc));
			end
			if (mon_out.valid && mon_out.ready) begin
				got = {mon_out.read_data, mon_out.key_column, mon_out.joy1_enable,
					mon_out.joy2_enable, mon_out.audio_gate, mon_out.tape_data_out,
					mon_out.tape_data_changed, mon_out.irq_mask, mon_out.cursor_reset_pulse,
					mon_out.audio_recheck_pulse, mon_out.irq_recheck_pulse, mon_out.pause_cmd};
				bad = "";
				if (response_q.size() == 0) begin
					bad = "unexpected result";
					want = 'x;
				end else begin
					want = response_q.pop_front();
					if (got.read_data !== want.read_data) bad = {bad, " read_data"};
					if (got.key_column !== want.key_column) bad = {bad, " key_column"};
					if (got.joy1_enable !== want.joy1_enable) bad = {bad, " joy1_enable"};
					if (got.joy2_enable !== want.joy2_enable) bad = {bad, " joy2_enable"};
					if (got.audio_gate !== want.audio_gate) bad = {bad, " audio_gate"};
					if (got.tape_data_out !== want.tape_data_out) bad = {bad, " tape_data_out"};
					if (got.tape_data_changed !== want.tape_data_changed)
						bad = {bad, " tape_data_changed"};
					if (got.irq_mask !== want.irq_mask) bad = {bad, " irq_mask"};
					if (got.cursor_reset_pulse !== want.cursor_reset_pulse)
						bad = {bad, " cursor_reset_pulse"};
					if (got.audio_recheck_pulse !== want.audio_recheck_pulse)
						bad = {bad, " audio_recheck_pulse"};
					if (got.irq_recheck_pulse !== want.irq_recheck_pulse)
						bad = {bad, " irq_recheck_pulse"};
					if (got.pause_cmd !== want.pause_cmd) bad = {bad, " pause_cmd"};
				end
				if (bad != "") begin
					fails <= fails + 1;
					if (reported < 10)
						$display("%0t: mismatch (%s): expected %h, got %h", $realtime, bad,
							want, got);
					reported = reported + 1;
				end
			end
			if (cfg_we)
				shortcut = cfg_wdata;
			pending <= response_q.size();
		end
	end

endmodule

@@ sim/parallel_port_keyboard_tape_io_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_keyboard_tape_io_tb
// Drives bus accesses into the parallel port with random gaps and result
// stalls: a directed pass over every port, operation and control word case,
// then random phases under both motor modes. A checker beside the port
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module parallel_port_keyboard_tape_io_tb;
	import ppio_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic steady;
	int   fails;
	int   pending;
	int   cycles = 0;

	ppio_in_if  in_ch();
	ppio_out_if out_ch();

	parallel_port_keyboard_tape_io uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	ppio_scoreboard u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mon_in    (in_ch),
		.mon_out   (out_ch),
		.fails     (fails),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 10);
	endfunction

	// side packs {vblank, cursor timer, tape data in, stopped, paused}.
	function automatic in_item_t access(op_t op, addr_t a, logic [7:0] wd,
			logic [7:0] pins, logic [4:0] side);
		in_item_t it;
		it.op = op;
		it.addr = a;
		it.wdata = wd;
		it.port_b_pins = pins;
		{it.vblank_in, it.cursor_timer_in, it.tape_data_in, it.tape_stopped,
			it.tape_paused} = side;
		return it;
	endfunction

	function automatic in_item_t random_access();
		in_item_t it;
		int       pick;
		it = access(OP_READ, addr_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
			5'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 30)
			it.op = OP_READ;
		else if (pick < 85)
			it.op = OP_WRITE;
		else if (pick < 95)
			it.op = OP_IRQ_SET;
		else
			it.op = OP_NOP;
		// Control writes lean toward the bit set/reset codes that do something.
		if (it.op == OP_WRITE && it.addr == ADDR_CTRL) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				it.wdata[7] = 1'b0;
				if ($urandom_range(0, 4) != 0)
					it.wdata[3] = 1'b0;
			end else if (pick < 8) begin
				it.wdata = MODE_CLEAR;
			end
		end
		return it;
	endfunction

	task automatic send(in_item_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.op, in_ch.addr, in_ch.wdata, in_ch.port_b_pins, in_ch.vblank_in,
			in_ch.cursor_timer_in, in_ch.tape_data_in, in_ch.tape_stopped,
			in_ch.tape_paused} <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Holds the sender until every result is back, then lets the pipeline go quiet.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_shortcut(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: a random stall before each item, then ready until it is taken.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_ch.valid <= 1'b0;
		{in_ch.op, in_ch.addr, in_ch.wdata, in_ch.port_b_pins, in_ch.vblank_in,
			in_ch.cursor_timer_in, in_ch.tape_data_in, in_ch.tape_stopped,
			in_ch.tape_paused} <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_shortcut(1'b0);

		// Port A, column selection and the no-column read.
		send(access(OP_READ,  ADDR_PORT_A, 8'h00, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_A, 8'h00, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_A, 8'hFF, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_PORT_A, 8'h00, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_A, 8'h79, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_PORT_A, 8'h00, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_A, 8'h9A, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_PORT_B, 8'h00, 8'hA5, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_B, 8'h3C, 8'h5A, 5'b00000));
		// Port C writes and motor edges under transport control.
		send(access(OP_WRITE, ADDR_PORT_C, 8'h0F, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_PORT_C, 8'h00, 8'h00, 5'b11100));
		send(access(OP_WRITE, ADDR_PORT_C, 8'h00, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   8'h07, 8'h00, 5'b00001));
		send(access(OP_WRITE, ADDR_CTRL,   8'h06, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   8'h07, 8'h00, 5'b00010));
		send(access(OP_WRITE, ADDR_CTRL,   8'h01, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   8'h03, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   8'h05, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   8'h0F, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_CTRL,   8'h00, 8'hFF, 5'b11111));
		send(access(OP_WRITE, ADDR_CTRL,   8'h9B, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_CTRL,   MODE_CLEAR, 8'h00, 5'b00000));
		send(access(OP_IRQ_SET, ADDR_PORT_A, 8'hFF, 8'h00, 5'b00000));
		send(access(OP_NOP,   ADDR_PORT_C, 8'hFE, 8'h00, 5'b00000));
		drain();

		// Shortcut mode: motor edges flip the sense bit read on port C.
		set_shortcut(1'b1);
		send(access(OP_WRITE, ADDR_CTRL,   8'h07, 8'h00, 5'b00000));
		send(access(OP_READ,  ADDR_PORT_C, 8'h00, 8'h00, 5'b00011));
		send(access(OP_WRITE, ADDR_CTRL,   8'h06, 8'h00, 5'b00000));
		send(access(OP_WRITE, ADDR_PORT_C, 8'h08, 8'h00, 5'b00000));
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			set_shortcut(phase[0]);
			for (int n = 0; n < 250; n++) begin
				if (n % 50 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send(random_access());
			end
			steady = 1'b0;
			drain();
		end

		repeat (6) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ parallel_port_keyboard_tape_io.f @@
design/ppio_pkg.sv
design/ppio_if.sv
design/ppio_in_stage.sv
design/ppio_core.sv
design/ppio_out_stage.sv
design/parallel_port_keyboard_tape_io.sv
design/ppio_checker.sv
sim/ppio_checker.sv
sim/parallel_port_keyboard_tape_io_tb.sv
